### hw/rtl/dlm_pkg.sv
package dlm_pkg;

  // default sizes
  localparam int BLOCK_BITS_DEF      = 48;
  localparam int SCALE_FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int TIME_W   = 48;
  localparam int WAIT_W   = 40;
  localparam int BCOUNT_W = 25;
  localparam int EXT_W    = 8;
  localparam int XFER_W   = 25;
  localparam int SPENT_W  = 32;
  localparam int ACC_W    = 24;
  localparam int RATE_W   = 16;
  localparam int EA_W     = EXT_W + ACC_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_ENABLED      = 3'd0;
  localparam cfg_idx_t REG_IS_SSD       = 3'd1;
  localparam cfg_idx_t REG_ACCESS_TIME  = 3'd2;
  localparam cfg_idx_t REG_READ_RATE    = 3'd3;
  localparam cfg_idx_t REG_WRITE_RATE   = 3'd4;
  localparam cfg_idx_t REG_TOTAL_BLOCKS = 3'd5;

  // timing constants
  localparam logic [TIME_W-1:0] USEC_PER_S      = 48'd1_000_000;
  localparam logic [TIME_W-1:0] IDLE_USEC_LIMIT = 48'd601_000_000;
  localparam int                SPINUP_USEC     = 8_000_000;
  localparam int                USEC_MULT_W     = 20;
  // bytes per megabit is 2^17
  localparam int                XFER_SHIFT      = 17;
  localparam int                XQ_W            = XFER_W + USEC_MULT_W - XFER_SHIFT;
  localparam logic [WAIT_W-1:0] WAIT_MAX        = {WAIT_W{1'b1}};

endpackage

### hw/rtl/dlm_req_if.sv
interface dlm_req_if #(
  parameter int BLOCK_BITS = dlm_pkg::BLOCK_BITS_DEF
) ();
  import dlm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [BLOCK_BITS-1:0] block_number;
  logic [BCOUNT_W-1:0]   byte_count;
  logic                  is_read;
  logic [EXT_W-1:0]      extent_count;
  logic [XFER_W-1:0]     transfer_bytes;
  logic [SPENT_W-1:0]    elapsed_usec;
  logic [TIME_W-1:0]     now_usec;

  modport source (output valid, block_number, byte_count, is_read, extent_count,
                  transfer_bytes, elapsed_usec, now_usec, input ready);
  modport sink   (input valid, block_number, byte_count, is_read, extent_count,
                  transfer_bytes, elapsed_usec, now_usec, output ready);
endinterface

### hw/rtl/dlm_rsp_if.sv
interface dlm_rsp_if ();
  import dlm_pkg::*;

  logic              valid;
  logic              ready;
  logic [WAIT_W-1:0] wait_usec;
  logic              spinup_added;

  modport source (output valid, wait_usec, spinup_added, input ready);
  modport sink   (input valid, wait_usec, spinup_added, output ready);
endinterface

### hw/rtl/dlm_cfg_if.sv
interface dlm_cfg_if #(
  parameter int DATA_W = dlm_pkg::BLOCK_BITS_DEF
) ();
  import dlm_pkg::*;

  logic              valid;
  logic              ready;
  cfg_idx_t          index;
  logic [DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/disk_latency_model_core.sv
// channel | direction | word
// req     | in        | block_number, byte_count, is_read, extent_count,
//         |           | transfer_bytes, elapsed_usec, now_usec
// rsp     | out       | wait_usec, spinup_added
// cfg     | in        | index, data (register write)
//
// one request at a time; a request is worked through by the bit-serial divider and
// shift-add multiplier; the distance divide is skipped in solid state mode or when the
// distance saturates. disabled requests go from S_IDLE straight to S_DONE. rst is
// synchronous and clears the state, the configuration and device state registers and
// rsp.valid, but not the request word or datapath registers; a stalled rsp word holds,
// and a new req word is taken meanwhile.
module disk_latency_model_core #(
  parameter int BLOCK_BITS      = dlm_pkg::BLOCK_BITS_DEF,
  parameter int SCALE_FRAC_BITS = dlm_pkg::SCALE_FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  dlm_req_if.sink   req,
  dlm_rsp_if.source rsp,
  dlm_cfg_if.sink   cfg
);
  import dlm_pkg::*;

  localparam int BB    = BLOCK_BITS;
  localparam int F     = SCALE_FRAC_BITS;
  localparam int DW    = BB + F;
  localparam int CNT_W = $clog2(DW);
  localparam int D_W   = F + 2;
  localparam int M2_W  = F + 4;
  localparam int M3_W  = F + 5;
  localparam int MA    = EA_W;
  localparam int MB    = (M3_W > USEC_MULT_W) ? M3_W : USEC_MULT_W;
  localparam int PW    = MA + MB;
  localparam int AD_W  = PW - F;
  localparam int SUM_W = (AD_W + 1 > WAIT_W + 1) ? AD_W + 1 : WAIT_W + 1;
  localparam logic [D_W-1:0]  Q_ONE   = D_W'(1) << F;
  localparam logic [D_W-1:0]  Q_SAT   = {D_W{1'b1}};
  localparam logic [M3_W-1:0] Q_ONE3  = M3_W'(1) << F;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DNORM, S_SEEK, S_SQ, S_CUBE, S_EA, S_FAC,
    S_SCALE, S_XMUL, S_XDIV, S_SUM, S_SUB, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic              enabled;
  logic              is_ssd;
  logic [ACC_W-1:0]  access_time;
  logic [RATE_W-1:0] read_rate;
  logic [RATE_W-1:0] write_rate;
  logic [BB-1:0]     total_blocks;

  // device state
  logic [BB-1:0]     last_block;
  logic [TIME_W-1:0] last_done;

  // request word
  logic [BB-1:0]       blk;
  logic [BCOUNT_W-1:0] bcount;
  logic                rd;
  logic [EXT_W-1:0]    ext;
  logic [XFER_W-1:0]   xfer;
  logic [SPENT_W-1:0]  spent;
  logic [TIME_W-1:0]   now;

  // working values
  logic                spin;
  logic [D_W-1:0]      seek_d;
  logic [D_W-1:0]      mag;
  logic                neg;
  logic [M3_W-1:0]     m3;
  logic [EA_W-1:0]     ea;
  logic [AD_W-1:0]     ad;
  logic [XQ_W-1:0]     tx;
  logic [WAIT_W-1:0]   delay;
  logic [WAIT_W-1:0]   wait_val;

  // serial units
  logic [CNT_W-1:0] cnt;
  logic [MA-1:0]    mul_a;
  logic [MB-1:0]    mul_b;
  logic [PW-1:0]    mul_acc;
  logic [DW-1:0]    div_q;
  logic [BB-1:0]    div_r;
  logic [BB-1:0]    div_d;

  // multiplier step: add multiplicand into the top, shift right
  logic [MA:0]   mul_sum;
  logic [PW-1:0] mul_step;
  always_comb begin
    mul_sum  = {1'b0, mul_acc[PW-1:MB]} + (mul_b[0] ? {1'b0, mul_a} : '0);
    mul_step = {mul_sum, mul_acc[MB-1:1]};
  end

  // divider step: restoring, one quotient bit per cycle
  logic [BB:0]   div_trial;
  logic          div_ge;
  logic [BB-1:0] div_r_step;
  logic [DW-1:0] div_q_step;
  always_comb begin
    div_trial  = {div_r, div_q[DW-1]};
    div_ge     = div_trial >= {1'b0, div_d};
    div_r_step = div_ge ? BB'(div_trial - {1'b0, div_d}) : div_trial[BB-1:0];
    div_q_step = {div_q[DW-2:0], div_ge};
  end

  // request preparation
  logic [BB-1:0]     total_eff;
  logic [BB-1:0]     diff;
  logic              dist_sat;
  logic [TIME_W-1:0] idle;
  logic              spin_now;
  logic [RATE_W-1:0] rate;
  always_comb begin
    total_eff = (total_blocks == '0) ? BB'(1) : total_blocks;
    diff      = (blk > last_block) ? blk - last_block : last_block - blk;
    dist_sat  = {2'b00, diff} >= {total_eff, 2'b00};
    idle      = now - last_done;
    spin_now  = !is_ssd && (now >= last_done) && (last_done >= USEC_PER_S) &&
                (idle >= IDLE_USEC_LIMIT);
    rate      = rd ? read_rate : write_rate;
  end

  // seek factor from the registered cube
  logic [M3_W-1:0] fac;
  always_comb begin
    if (neg) begin
      fac = (m3 >= Q_ONE3) ? '0 : Q_ONE3 - m3;
    end else begin
      fac = Q_ONE3 + m3;
    end
  end

  // delay sums
  logic [SUM_W-1:0]  sum;
  logic [TIME_W:0]   done_sum;
  always_comb begin
    sum = SUM_W'(ad) + SUM_W'(tx) + (spin ? SUM_W'(SPINUP_USEC) : '0);
    done_sum = {1'b0, now} + (TIME_W + 1)'(wait_val);
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      enabled      <= 1'b0;
      is_ssd       <= 1'b0;
      access_time  <= '0;
      read_rate    <= '0;
      write_rate   <= '0;
      total_blocks <= BB'(1);
      last_block   <= '0;
      last_done    <= '0;
      rsp.valid    <= 1'b0;
      cnt          <= '0;
    end else begin
      // register writes
      if (cfg.valid) begin
        case (cfg.index)
          REG_ENABLED:      enabled      <= cfg.data[0];
          REG_IS_SSD:       is_ssd       <= cfg.data[0];
          REG_ACCESS_TIME:  access_time  <= cfg.data[ACC_W-1:0];
          REG_READ_RATE:    read_rate    <= cfg.data[RATE_W-1:0];
          REG_WRITE_RATE:   write_rate   <= cfg.data[RATE_W-1:0];
          REG_TOTAL_BLOCKS: total_blocks <= cfg.data[BB-1:0];
          default: ;
        endcase
      end

      // result taken while no new word is being loaded
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            blk      <= req.block_number;
            bcount   <= req.byte_count;
            rd       <= req.is_read;
            ext      <= req.extent_count;
            xfer     <= req.transfer_bytes;
            spent    <= req.elapsed_usec;
            now      <= req.now_usec;
            spin     <= 1'b0;
            wait_val <= '0;
            state    <= enabled ? S_PREP : S_DONE;
          end
        end
        S_PREP: begin
          spin <= spin_now;
          if (is_ssd) begin
            seek_d <= Q_ONE;
            state  <= S_SEEK;
          end else begin
            last_block <= blk + BB'(bcount);
            if (dist_sat) begin
              seek_d <= Q_SAT;
              state  <= S_SEEK;
            end else begin
              div_q <= {diff, {F{1'b0}}};
              div_r <= '0;
              div_d <= total_eff;
              cnt   <= CNT_W'(DW - 1);
              state <= S_DNORM;
            end
          end
        end
        S_DNORM: begin
          div_q <= div_q_step;
          div_r <= div_r_step;
          cnt   <= cnt - 1'b1;
          if (cnt == '0) begin
            seek_d <= D_W'(div_q_step);
            state  <= S_SEEK;
          end
        end
        S_SEEK: begin
          neg     <= seek_d < Q_ONE;
          mag     <= (seek_d < Q_ONE) ? Q_ONE - seek_d : seek_d - Q_ONE;
          mul_a   <= MA'((seek_d < Q_ONE) ? Q_ONE - seek_d : seek_d - Q_ONE);
          mul_b   <= MB'((seek_d < Q_ONE) ? Q_ONE - seek_d : seek_d - Q_ONE);
          mul_acc <= '0;
          cnt     <= CNT_W'(MB - 1);
          state   <= S_SQ;
        end
        S_SQ: begin
          if (cnt == '0) begin
            mul_a   <= MA'(M2_W'(mul_step >> F));
            mul_b   <= MB'(mag);
            mul_acc <= '0;
            cnt     <= CNT_W'(MB - 1);
            state   <= S_CUBE;
          end else begin
            mul_acc <= mul_step;
            mul_b   <= mul_b >> 1;
            cnt     <= cnt - 1'b1;
          end
        end
        S_CUBE: begin
          if (cnt == '0) begin
            m3      <= M3_W'(mul_step >> F);
            mul_a   <= MA'(access_time);
            mul_b   <= MB'(ext);
            mul_acc <= '0;
            cnt     <= CNT_W'(MB - 1);
            state   <= S_EA;
          end else begin
            mul_acc <= mul_step;
            mul_b   <= mul_b >> 1;
            cnt     <= cnt - 1'b1;
          end
        end
        S_EA: begin
          mul_acc <= mul_step;
          mul_b   <= mul_b >> 1;
          cnt     <= cnt - 1'b1;
          if (cnt == '0) begin
            ea    <= EA_W'(mul_step);
            state <= S_FAC;
          end
        end
        S_FAC: begin
          mul_a   <= ea;
          mul_b   <= MB'(fac);
          mul_acc <= '0;
          cnt     <= CNT_W'(MB - 1);
          state   <= S_SCALE;
        end
        S_SCALE: begin
          if (cnt == '0) begin
            ad <= AD_W'(mul_step >> F);
            if (rate == '0) begin
              tx    <= '0;
              state <= S_SUM;
            end else begin
              mul_a   <= MA'(xfer);
              mul_b   <= MB'(USEC_PER_S);
              mul_acc <= '0;
              cnt     <= CNT_W'(MB - 1);
              state   <= S_XMUL;
            end
          end else begin
            mul_acc <= mul_step;
            mul_b   <= mul_b >> 1;
            cnt     <= cnt - 1'b1;
          end
        end
        S_XMUL: begin
          if (cnt == '0) begin
            div_q <= DW'(XQ_W'(mul_step >> XFER_SHIFT)) << (DW - XQ_W);
            div_r <= '0;
            div_d <= BB'(rate);
            cnt   <= CNT_W'(XQ_W - 1);
            state <= S_XDIV;
          end else begin
            mul_acc <= mul_step;
            mul_b   <= mul_b >> 1;
            cnt     <= cnt - 1'b1;
          end
        end
        S_XDIV: begin
          div_q <= div_q_step;
          div_r <= div_r_step;
          cnt   <= cnt - 1'b1;
          if (cnt == '0) begin
            tx    <= XQ_W'(div_q_step);
            state <= S_SUM;
          end
        end
        S_SUM: begin
          delay <= (|sum[SUM_W-1:WAIT_W]) ? WAIT_MAX : sum[WAIT_W-1:0];
          state <= S_SUB;
        end
        S_SUB: begin
          wait_val <= (delay > WAIT_W'(spent)) ? delay - WAIT_W'(spent) : '0;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.wait_usec    <= wait_val;
            rsp.spinup_added <= spin;
            if (enabled) begin
              last_done <= done_sum[TIME_W] ? {TIME_W{1'b1}} : done_sum[TIME_W-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### bench/dlm_checker.sv
`timescale 1ns / 100ps

module dlm_checker
  import dlm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dlm_req_if req,
  dlm_rsp_if rsp,
  dlm_cfg_if cfg,
  output int   fail_count,
  output int   pending,
  output int   words_checked,
  output int   spinups_seen
);

  localparam int F = SCALE_FRAC_BITS_DEF;
  localparam logic [63:0] Q_ONE = 64'd1 << F;
  localparam logic [63:0] TIME_MAX = (64'd1 << TIME_W) - 1;

  typedef struct packed {
    logic [WAIT_W-1:0] wait_usec;
    logic              spinup_added;
  } latency_t;

  // shadow registers and state
  logic               en_q, ssd_q;
  logic [ACC_W-1:0]   acc_q;
  logic [RATE_W-1:0]  rd_rate_q, wr_rate_q;
  logic [TIME_W-1:0]  total_q;
  logic [TIME_W-1:0]  last_block_q, last_done_q;
  latency_t           latency_q[$];

  // normalized distance, saturated below 4.0
  function automatic logic [63:0] scaled_distance(logic [63:0] num, logic [63:0] den);
    logic [127:0] q;
    q = ({64'd0, num} << F) / den;
    if (q >= (128'd4 << F)) return (64'd4 << F) - 1;
    return q[63:0];
  endfunction

  function automatic logic [63:0] seek_scale(logic [63:0] d);
    logic        neg;
    logic [63:0] m, m2, m3;
    neg = d < Q_ONE;
    m   = neg ? Q_ONE - d : d - Q_ONE;
    m2  = (m * m) >> F;
    m3  = (m2 * m) >> F;
    if (neg) return (m3 >= Q_ONE) ? 64'd0 : Q_ONE - m3;
    return Q_ONE + m3;
  endfunction

  function automatic latency_t request_latency();
    latency_t     r;
    logic [63:0]  tot, diff, d, delay, rate, spent, now;
    logic [127:0] prod;
    r = '0;
    if (!en_q) return r;
    tot = (total_q == 0) ? 64'd1 : 64'(total_q);
    if (!ssd_q) begin
      diff = (req.block_number > last_block_q) ? req.block_number - last_block_q
                                               : last_block_q - req.block_number;
      d = scaled_distance(diff, tot);
      last_block_q = req.block_number + TIME_W'(req.byte_count);
    end else begin
      d = Q_ONE;
    end
    prod  = 128'(req.extent_count) * 128'(acc_q) * 128'(seek_scale(d));
    delay = 64'(prod >> F);
    rate  = req.is_read ? 64'(rd_rate_q) : 64'(wr_rate_q);
    if (rate != 0) delay += (64'(req.transfer_bytes) * 64'd1000000) / (rate * 64'd131072);
    now = 64'(req.now_usec);
    if (!ssd_q && now >= last_done_q && last_done_q >= 64'd1000000 &&
        (now - last_done_q) / 64'd1000000 > 64'd600) begin
      delay += 64'd8000000;
      r.spinup_added = 1'b1;
    end
    if (delay > 64'(WAIT_MAX)) delay = 64'(WAIT_MAX);
    spent = 64'(req.elapsed_usec);
    delay = (delay > spent) ? delay - spent : 64'd0;
    last_done_q = (now + delay > TIME_MAX) ? TIME_MAX[TIME_W-1:0] : TIME_W'(now + delay);
    r.wait_usec = delay[WAIT_W-1:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    fail_count++;
  endtask

  assign pending = latency_q.size();

  // watch configuration writes, requests and results
  always @(posedge clk) begin
    latency_t e;
    if (rst) begin
      en_q = 0; ssd_q = 0; acc_q = 0; rd_rate_q = 0; wr_rate_q = 0; total_q = 1;
      last_block_q = 0; last_done_q = 0;
      latency_q.delete();
      fail_count = 0; words_checked = 0; spinups_seen = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (latency_q.size() == 0) begin
          report("unexpected word", rsp.wait_usec, 0);
        end else begin
          e = latency_q.pop_front();
          if (rsp.wait_usec !== e.wait_usec) report("wait_usec", rsp.wait_usec, e.wait_usec);
          if (rsp.spinup_added !== e.spinup_added)
            report("spinup_added", rsp.spinup_added, e.spinup_added);
          words_checked++;
          if (e.spinup_added) spinups_seen++;
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ENABLED:      en_q = cfg.data[0];
          REG_IS_SSD:       ssd_q = cfg.data[0];
          REG_ACCESS_TIME:  acc_q = cfg.data[ACC_W-1:0];
          REG_READ_RATE:    rd_rate_q = cfg.data[RATE_W-1:0];
          REG_WRITE_RATE:   wr_rate_q = cfg.data[RATE_W-1:0];
          REG_TOTAL_BLOCKS: total_q = cfg.data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) latency_q.push_back(request_latency());
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dlm_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, pending, words_checked, spinups_seen;
  int   idle_cycles;
  int   rand_idle;
  logic sink_stall_on = 1;
  logic [TIME_W-1:0] now_t;

  dlm_req_if req ();
  dlm_rsp_if rsp ();
  dlm_cfg_if cfg ();

  disk_latency_model_core dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  dlm_checker checker_i (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
    .fail_count(fail_count), .pending(pending),
    .words_checked(words_checked), .spinups_seen(spinups_seen)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // result side stalls in bursts
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 0;
    end else if (!sink_stall_on) begin
      rsp.ready <= 1;
    end else if (rsp.ready) begin
      if ($urandom_range(0, 3) == 0) begin
        rsp.ready <= 0;
        rand_idle = $urandom_range(1, 5);
      end
    end else begin
      if (rand_idle <= 1) rsp.ready <= 1;
      rand_idle--;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout with %0d words outstanding", pending);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [TIME_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1; cfg.index <= idx; cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  // wait until every expected word came back and the core has settled
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic configure(logic en, logic ssd, logic [ACC_W-1:0] acc,
                           logic [RATE_W-1:0] rr, logic [RATE_W-1:0] wr,
                           logic [TIME_W-1:0] tot);
    drain();
    write_reg(REG_ENABLED, TIME_W'(en));
    write_reg(REG_IS_SSD, TIME_W'(ssd));
    write_reg(REG_ACCESS_TIME, TIME_W'(acc));
    write_reg(REG_READ_RATE, TIME_W'(rr));
    write_reg(REG_WRITE_RATE, TIME_W'(wr));
    write_reg(REG_TOTAL_BLOCKS, tot);
  endtask

  task automatic send(logic [TIME_W-1:0] blk, logic [BCOUNT_W-1:0] bc, logic rd,
                      logic [EXT_W-1:0] ext, logic [XFER_W-1:0] xf,
                      logic [SPENT_W-1:0] el, logic [TIME_W-1:0] now, logic gaps);
    int g;
    @(negedge clk);
    if (gaps && $urandom_range(0, 3) == 0) begin
      g = $urandom_range(1, 5);
      repeat (g) @(negedge clk);
    end
    req.valid <= 1; req.block_number <= blk; req.byte_count <= bc; req.is_read <= rd;
    req.extent_count <= ext; req.transfer_bytes <= xf; req.elapsed_usec <= el;
    req.now_usec <= now;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    req.valid <= 0;
  endtask

  // random request; time mostly moves forward, sometimes with long idle gaps
  task automatic send_random(logic gaps);
    logic [TIME_W-1:0] blk;
    logic [SPENT_W-1:0] el;
    case ($urandom_range(0, 9))
      0: now_t = now_t + TIME_W'({$urandom, $urandom} % 64'd2_000_000_000);
      1: now_t = TIME_W'({$urandom, $urandom});
      2: now_t = now_t - TIME_W'($urandom_range(0, 5_000_000));
      default: now_t = now_t + TIME_W'($urandom_range(0, 3_000_000));
    endcase
    blk = ($urandom_range(0, 3) == 0) ? TIME_W'({$urandom, $urandom})
                                      : TIME_W'($urandom_range(0, 5000));
    el  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20000);
    send(blk, 25'($urandom_range(0, 16777216)), 1'($urandom_range(0, 1)),
         8'($urandom_range(1, 255)), 25'($urandom_range(0, 16777216)), el, now_t, gaps);
  endtask

  initial begin
    req.valid = 0; req.block_number = 0; req.byte_count = 0; req.is_read = 0;
    req.extent_count = 1; req.transfer_bytes = 0; req.elapsed_usec = 0; req.now_usec = 0;
    cfg.valid = 0; cfg.index = REG_ENABLED; cfg.data = 0;
    now_t = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: disabled, then spinning disk extremes
    send(48'hFFFF_FFFF_FFFF, 25'd16777216, 1'b1, 8'd255, 25'd16777216, 32'd0, 48'd5, 1'b0);
    configure(1'b1, 1'b0, 24'd100, 16'd1, 16'd0, 48'd1000);
    send(48'd0, 25'd0, 1'b0, 8'd1, 25'd0, 32'd0, 48'd0, 1'b0);
    send(48'd500, 25'd0, 1'b0, 8'd1, 25'd1000, 32'd0, 48'd10, 1'b0);
    send(48'd0, 25'd4, 1'b1, 8'd255, 25'd16777216, 32'd0, 48'd20, 1'b0);
    send(48'hFFFF_FFFF_FFFF, 25'd16777216, 1'b1, 8'd1, 25'd0, 32'hFFFF_FFFF, 48'd30, 1'b0);
    send(48'd1000, 25'd0, 1'b1, 8'd2, 25'd10, 32'd0, 48'd2_000_000, 1'b0);
    // long idle spin-up, then clock going backwards
    send(48'd1000, 25'd0, 1'b1, 8'd2, 25'd10, 32'd0, 48'd700_000_000, 1'b0);
    send(48'd1000, 25'd0, 1'b1, 8'd2, 25'd10, 32'd0, 48'd1_000, 1'b0);
    send(48'd1000, 25'd0, 1'b1, 8'd2, 25'd10, 32'd0, 48'hFFFF_FFFF_FFFF, 1'b0);
    send(48'd1000, 25'd0, 1'b1, 8'd2, 25'd10, 32'd9_000_000, 48'hFFFF_FFFF_FFFF, 1'b0);
    // saturation of delay and zero block count
    configure(1'b1, 1'b0, 24'hFF_FFFF, 16'd1, 16'd1, 48'd0);
    send(48'd3, 25'd0, 1'b1, 8'd255, 25'd16777216, 32'd0, 48'd100, 1'b0);
    send(48'd0, 25'd1, 1'b0, 8'd255, 25'd16777216, 32'd0, 48'd200, 1'b0);
    configure(1'b1, 1'b1, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    send(48'd7, 25'd0, 1'b1, 8'd255, 25'd16777216, 32'd0, 48'hFFFF_FFFF_0000, 1'b0);
    send(48'd9, 25'd0, 1'b0, 8'd1, 25'd1, 32'd5, 48'd0, 1'b0);

    // random phases with varied settings
    for (int p = 0; p < 8; p++) begin
      if (p == 7) sink_stall_on = 0;
      configure(p != 2, p[0], (p == 5) ? 24'hFF_FFFF : 24'($urandom_range(0, 20000)),
                16'($urandom), (p == 4) ? 16'd0 : 16'($urandom_range(0, 800)),
                (p == 6) ? 48'hFFFF_FFFF_FFFF : 48'($urandom_range(1, 100000)));
      for (int i = 0; i < 48; i++) begin
        send_random(p != 7);
        // let all results drain once, midway through phase 3
        if (i == 20 && p == 3) while (pending != 0) @(posedge clk);
      end
    end

    drain();
    $display("covered %0d result words, %0d with spin-up, over 11 register settings",
             words_checked, spinups_seen);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
